[rtl/core/three_axis_ramp_interpolator_top_assert.svh]
`ifndef THREE_AXIS_RAMP_INTERPOLATOR_TOP_ASSERT_SVH
`define THREE_AXIS_RAMP_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TARI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ramp interpolator check failed");

// Next-cycle implication, disabled while reset is high.
`define TARI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ramp interpolator check failed");

// Checks the cycle that follows reset.
`define TARI_ASSERT_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("ramp interpolator reset check failed");

`endif

[rtl/core/tari_pkg.sv]
package tari_pkg;

   localparam int VALUE_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int DIV_WIDTH       = VALUE_WIDTH + 1;
   localparam int STEP_CNT_WIDTH  = $clog2(DIV_WIDTH);
   localparam int AXES            = 3;
   localparam int AXIS_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_X = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_Y = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_Z = CSR_INDEX_WIDTH'(2);

   localparam logic [AXIS_WIDTH-1:0] AXIS_X = AXIS_WIDTH'(0);
   localparam logic [AXIS_WIDTH-1:0] AXIS_Z = AXIS_WIDTH'(2);

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic                        start;
      logic signed [DIV_WIDTH-1:0] dividend;
      count_type                   divisor;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [DIV_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/tari_div.sv]
module tari_div import tari_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [2:0] {D_IDLE, D_ABS, D_RUN, D_SIGN, D_DONE} div_state_type;

   localparam logic [STEP_CNT_WIDTH-1:0] STEP_LAST = STEP_CNT_WIDTH'(DIV_WIDTH - 1);

   div_state_type             state_ff;
   logic [STEP_CNT_WIDTH-1:0] step_ff;
   logic [COUNT_WIDTH-1:0]    rem_ff;
   logic [DIV_WIDTH-1:0]      quo_ff;
   logic                      neg_ff;
   count_type                 divisor_ff;

   logic [COUNT_WIDTH:0] rem_shift;
   logic [COUNT_WIDTH:0] rem_diff;
   logic                 fits;

   assign rem_shift = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               if (div_req.start) begin
                  quo_ff     <= div_req.dividend;
                  neg_ff     <= div_req.dividend[DIV_WIDTH-1];
                  divisor_ff <= div_req.divisor;
                  rem_ff     <= '0;
                  step_ff    <= '0;
                  state_ff   <= D_ABS;
               end
            end
            D_ABS: begin
               if (neg_ff) begin
                  quo_ff <= -quo_ff;
               end
               state_ff <= D_RUN;
            end
            D_RUN: begin
               rem_ff  <= fits ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
               quo_ff  <= {quo_ff[DIV_WIDTH-2:0], fits};
               step_ff <= step_ff + STEP_CNT_WIDTH'(1);
               if (step_ff == STEP_LAST) begin
                  state_ff <= D_SIGN;
               end
            end
            D_SIGN: begin
               if (neg_ff) begin
                  quo_ff <= -quo_ff;
               end
               state_ff <= D_DONE;
            end
            D_DONE: begin
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign div_rsp.done     = (state_ff == D_DONE);
   assign div_rsp.quotient = signed'(quo_ff);

endmodule

[rtl/core/three_axis_ramp_interpolator_top.sv]
// Three-axis linear ramp interpolator. A load item sets the three current
// components and the tick count (a zero count sets them to the targets);
// each later tick item moves every component by (target - current) divided
// by the ticks left, truncated toward zero and wrapped to 16 bits, then
// counts down and snaps to the targets when the count reaches zero. The
// user must write targets through the csr port only while the block is
// idle; the block itself does not enforce this. A load item, or a tick
// while no ramp is active, goes to the finish state, which puts its result
// in the output register once that register is free and then returns to
// idle. A moving tick runs the three divisions one after another on a
// single bit-serial divider, updates the count and then registers the
// result. req_stall stays high until the result has been placed in the
// output register, which holds it until it is taken.
module three_axis_ramp_interpolator_top import tari_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic signed [VALUE_WIDTH-1:0] req_start_x,
   input  logic signed [VALUE_WIDTH-1:0] req_start_y,
   input  logic signed [VALUE_WIDTH-1:0] req_start_z,
   input  logic [COUNT_WIDTH-1:0]        req_tick_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_cur_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_cur_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_cur_z,
   output logic [COUNT_WIDTH-1:0]        rsp_ticks_remaining,
   output logic                          rsp_done_res,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [VALUE_WIDTH-1:0]        csr_wdata
);

   typedef enum logic [2:0] {T_IDLE, T_START, T_WAIT, T_FINAL, T_FINISH} top_state_type;

   top_state_type         state_ff;
   logic [AXIS_WIDTH-1:0] axis_ff;
   value_type             cur_ff [AXES];
   value_type             target_ff [AXES];
   count_type             ticks_ff;
   logic                  done_ff;
   logic                  rsp_valid_ff;
   value_type             rsp_x_ff;
   value_type             rsp_y_ff;
   value_type             rsp_z_ff;
   count_type             rsp_ticks_ff;
   logic                  rsp_done_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;
   value_type   cur_sum;
   count_type   ticks_dec;
   logic        out_free;

   tari_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req.start    = (state_ff == T_START);
   assign div_req.dividend = DIV_WIDTH'(target_ff[axis_ff]) - DIV_WIDTH'(cur_ff[axis_ff]);
   assign div_req.divisor  = ticks_ff;

   assign cur_sum   = cur_ff[axis_ff] + value_type'(div_rsp.quotient[VALUE_WIDTH-1:0]);
   assign ticks_dec = ticks_ff - COUNT_WIDTH'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '{default: '0};
      end else if (csr_we && (csr_index <= CSR_TARGET_Z)) begin
         target_ff[csr_index] <= signed'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         axis_ff      <= AXIS_X;
         cur_ff       <= '{default: '0};
         ticks_ff     <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != T_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (req_valid) begin
                  if (req_type == REQ_LOAD) begin
                     if (req_tick_count == '0) begin
                        cur_ff  <= target_ff;
                        done_ff <= 1'b1;
                     end else begin
                        cur_ff[0] <= req_start_x;
                        cur_ff[1] <= req_start_y;
                        cur_ff[2] <= req_start_z;
                        done_ff   <= 1'b0;
                     end
                     ticks_ff <= req_tick_count;
                     state_ff <= T_FINISH;
                  end else if (ticks_ff == '0) begin
                     done_ff  <= 1'b1;
                     state_ff <= T_FINISH;
                  end else begin
                     axis_ff  <= AXIS_X;
                     state_ff <= T_START;
                  end
               end
            end
            T_START: begin
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (div_rsp.done) begin
                  cur_ff[axis_ff] <= cur_sum;
                  if (axis_ff == AXIS_Z) begin
                     state_ff <= T_FINAL;
                  end else begin
                     axis_ff  <= axis_ff + AXIS_WIDTH'(1);
                     state_ff <= T_START;
                  end
               end
            end
            T_FINAL: begin
               ticks_ff <= ticks_dec;
               if (ticks_dec == '0) begin
                  cur_ff  <= target_ff;
                  done_ff <= 1'b1;
               end else begin
                  done_ff <= 1'b0;
               end
               state_ff <= T_FINISH;
            end
            T_FINISH: begin
               if (out_free) begin
                  rsp_x_ff     <= cur_ff[0];
                  rsp_y_ff     <= cur_ff[1];
                  rsp_z_ff     <= cur_ff[2];
                  rsp_ticks_ff <= ticks_ff;
                  rsp_done_ff  <= done_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != T_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cur_x           = rsp_x_ff;
   assign rsp_cur_y           = rsp_y_ff;
   assign rsp_cur_z           = rsp_z_ff;
   assign rsp_ticks_remaining = rsp_ticks_ff;
   assign rsp_done_res        = rsp_done_ff;

endmodule

[rtl/core/tari_checker.sv]
`include "three_axis_ramp_interpolator_top_assert.svh"

module tari_checker import tari_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [COUNT_WIDTH-1:0]        rsp_ticks_remaining,
   input logic                          rsp_done_res
);

   `TARI_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `TARI_ASSERT_IMP(a_done_matches_count, rsp_valid, rsp_done_res == (rsp_ticks_remaining == '0))
   `TARI_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `TARI_ASSERT_RST(a_no_result_after_reset, !rsp_valid)

endmodule

bind three_axis_ramp_interpolator_top tari_checker u_tari_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_ticks_remaining (rsp_ticks_remaining),
   .rsp_done_res        (rsp_done_res)
);
